// ===== rtl/core/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID and heater PWM controller package
// Shared widths, constants, register indexes and the per-tick control struct.
// ----------------------------------------------------------------------------
package fpc_pkg;

   // Field widths of one word on each channel.
   localparam int unsigned TEMP_W     = 10;
   localparam int unsigned FAN_W      = 8;
   localparam int unsigned HDUTY_W    = 4;

   // Register widths.
   localparam int unsigned GAIN_W     = 10;
   localparam int unsigned TARGET_W   = 8;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned CSR_IDX_W  = 3;

   // Controller state widths.
   localparam int unsigned ERR_W      = 11;
   localparam int unsigned SUM_W      = 24;
   localparam int unsigned CNT_W      = 4;

   // Fan clamp limits and heater PWM period in ticks.
   localparam logic [FAN_W-1:0] FAN_MIN     = 8'd10;
   localparam logic [FAN_W-1:0] FAN_MAX     = 8'd255;
   localparam logic [CNT_W-1:0] HEAT_PERIOD = 4'd10;

   // Register reset values.
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 10'd16;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 10'd2;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 10'd0;
   localparam logic [TARGET_W-1:0] TARGET_RST     = 8'd40;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_TARGET_TEMP = 3'd3,
      CSR_AUTO_MODE   = 3'd4
   } csr_index_type;

   // Control handed from the top level to the state-holding units.
   typedef struct packed {
      logic advance;    // one word moves from the input stage to the result stage
      logic auto_mode;  // the word is processed in automatic mode
   } step_type;

endpackage

// ===== rtl/core/fpc_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID and heater PWM controller channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------

// Request channel: one control tick per word.
interface fpc_req_if
   import fpc_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [TEMP_W-1:0]  temp_sample;
   logic [FAN_W-1:0]   fan_duty_manual;
   logic [HDUTY_W-1:0] heater_duty_manual;

   modport source (output valid, output temp_sample, output fan_duty_manual,
                   output heater_duty_manual, input ready);
   modport sink   (input valid, input temp_sample, input fan_duty_manual,
                   input heater_duty_manual, output ready);
endinterface

// Response channel: fan duty and heater level for one tick.
interface fpc_rsp_if
   import fpc_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [FAN_W-1:0] fan_duty;
   logic             heater_on;

   modport source (output valid, output fan_duty, output heater_on, input ready);
   modport sink   (input valid, input fan_duty, input heater_on, output ready);
endinterface

// ===== rtl/core/fpc_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID unit
// Computes the clamped PID fan duty and keeps the error sum and last error.
// ----------------------------------------------------------------------------
module fpc_pid
   import fpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  step_type            step,
   input  logic [TEMP_W-1:0]   temp_sample,
   input  logic [GAIN_W-1:0]   prop_gain,
   input  logic [GAIN_W-1:0]   integ_gain,
   input  logic [GAIN_W-1:0]   deriv_gain,
   input  logic [TARGET_W-1:0] target_temp,
   output logic [FAN_W-1:0]    fan_auto
);

   localparam int unsigned ACC_W = 36;

   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] prev_error_ff;

   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W:0]     diff;
   logic signed [21:0]        p_prod;
   logic signed [34:0]        i_prod;
   logic signed [22:0]        d_prod;
   logic signed [ACC_W-1:0]   acc;
   logic signed [SUM_W:0]     sum_wide;

   // Error in whole degrees: the sample halved minus the setpoint.
   assign err  = $signed({2'b00, temp_sample[TEMP_W-1:1]}) - $signed({3'b000, target_temp});
   assign diff = $signed({err[ERR_W-1], err}) - $signed({prev_error_ff[ERR_W-1], prev_error_ff});

   // Three independent products, then one signed sum.
   assign p_prod = $signed({1'b0, prop_gain})  * err;
   assign i_prod = $signed({1'b0, integ_gain}) * error_sum_ff;
   assign d_prod = $signed({1'b0, deriv_gain}) * diff;
   assign acc    = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);

   // Clamp the duty into the fan's working range.
   always_comb begin
      if (acc > $signed({28'd0, FAN_MAX})) begin
         fan_auto = FAN_MAX;
      end else if (acc < $signed({28'd0, FAN_MIN})) begin
         fan_auto = FAN_MIN;
      end else begin
         fan_auto = acc[FAN_W-1:0];
      end
   end

   // Saturating accumulation of the error.
   always_comb begin
      sum_wide = $signed({error_sum_ff[SUM_W-1], error_sum_ff})
               + $signed({{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         error_sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
   end

   // PID state moves only on automatic ticks.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
      end else if (step.advance && step.auto_mode) begin
         error_sum_ff  <= error_sum_in;
         prev_error_ff <= err;
      end
   end

endmodule

// ===== rtl/core/fpc_heat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater PWM unit
// Ten-tick software PWM counter and heater drive level.
// ----------------------------------------------------------------------------
module fpc_heat
   import fpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  logic [HDUTY_W-1:0] heater_duty_manual,
   output logic               heater_level_in
);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             heater_level_ff;
   logic [CNT_W-1:0] cnt_inc;

   assign cnt_inc = cnt_ff + CNT_W'(1);

   // Next count and level; automatic mode forces the heater on.
   always_comb begin
      cnt_in          = cnt_ff;
      heater_level_in = heater_level_ff;
      if (step.auto_mode) begin
         heater_level_in = 1'b1;
      end else begin
         cnt_in = cnt_inc;
         if (cnt_inc >= heater_duty_manual) begin
            heater_level_in = 1'b0;
         end
         if (cnt_inc == HEAT_PERIOD) begin
            cnt_in = '0;
            if (heater_duty_manual != '0) begin
               heater_level_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff          <= '0;
         heater_level_ff <= 1'b0;
      end else if (step.advance) begin
         cnt_ff          <= cnt_in;
         heater_level_ff <= heater_level_in;
      end
   end

`ifndef SYNTHESIS
   // The counter wraps at the period and never passes it.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= HEAT_PERIOD)
      else $error("heater PWM counter beyond its period");

   // An automatic tick leaves the heater on and the counter untouched.
   a_auto_hold: assert property (@(posedge clock) disable iff (reset)
      step.advance && step.auto_mode |=> heater_level_ff && $stable(cnt_ff))
      else $error("automatic tick changed the PWM counter or left heater off");

   // A manual tick with zero duty always turns the heater off.
   a_zero_duty: assert property (@(posedge clock) disable iff (reset)
      step.advance && !step.auto_mode && heater_duty_manual == '0 |=> !heater_level_ff)
      else $error("heater on with zero manual duty");
`endif

endmodule

// ===== rtl/core/fan_pid_heater_pwm_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID and heater PWM controller
// Per tick: PID fan duty and heater on in automatic mode, manual duties otherwise.
// ----------------------------------------------------------------------------
// Accepted words go from the input register to the result register, then out.
// Throughput: one word per cycle while the response side takes words; the input
// register and the result register each hold one word, and the PID state is
// updated as each automatic word passes between.
// Reset (synchronous, active high) clears both stages, the PID state and the
// PWM counter, and loads the register defaults; there is no clearing pass.
module fan_pid_heater_pwm_controller
   import fpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fpc_req_if.sink               req_chan,
   fpc_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [GAIN_W-1:0]   prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [TARGET_W-1:0] target_temp_ff;
   logic                auto_mode_ff;

   // Input stage.
   logic               in_valid_ff;
   logic [TEMP_W-1:0]  temp_ff;
   logic [FAN_W-1:0]   fan_man_ff;
   logic [HDUTY_W-1:0] heat_duty_ff;

   // Result stage.
   logic             rsp_valid_ff;
   logic [FAN_W-1:0] fan_duty_ff, fan_duty_in;
   logic             heater_on_ff;

   logic             out_free;
   logic             in_take;
   step_type         step;
   logic [FAN_W-1:0] fan_auto;
   logic             heater_level_in;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         target_temp_ff <= TARGET_RST;
         auto_mode_ff   <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_TARGET_TEMP: target_temp_ff <= csr_wdata[TARGET_W-1:0];
            CSR_AUTO_MODE:   auto_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Flow control: a word advances when the result register is free or draining.
   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign step.advance    = in_valid_ff && out_free;
   assign step.auto_mode  = auto_mode_ff;
   assign req_chan.ready  = !in_valid_ff || out_free;
   assign in_take         = req_chan.valid && req_chan.ready;

   // Input stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         temp_ff      <= req_chan.temp_sample;
         fan_man_ff   <= req_chan.fan_duty_manual;
         heat_duty_ff <= req_chan.heater_duty_manual;
      end
   end

   fpc_pid u_pid (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .temp_sample (temp_ff),
      .prop_gain   (prop_gain_ff),
      .integ_gain  (integ_gain_ff),
      .deriv_gain  (deriv_gain_ff),
      .target_temp (target_temp_ff),
      .fan_auto    (fan_auto)
   );

   fpc_heat u_heat (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .heater_duty_manual (heat_duty_ff),
      .heater_level_in    (heater_level_in)
   );

   // Fan duty source follows the mode.
   assign fan_duty_in = auto_mode_ff ? fan_auto : fan_man_ff;

   // Result stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step.advance) begin
         fan_duty_ff  <= fan_duty_in;
         heater_on_ff <= heater_level_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fan_duty  = fan_duty_ff;
   assign rsp_chan.heater_on = heater_on_ff;

`ifndef SYNTHESIS
   // Automatic words come out with the fan inside its clamp and the heater on.
   a_auto_result: assert property (@(posedge clock) disable iff (reset)
      step.advance && step.auto_mode |=> fan_duty_ff >= FAN_MIN && heater_on_ff)
      else $error("automatic result outside the fan clamp or heater off");

   // Manual words pass the manual fan duty through.
   a_manual_fan: assert property (@(posedge clock) disable iff (reset)
      step.advance && !step.auto_mode |=> fan_duty_ff == $past(fan_man_ff))
      else $error("manual fan duty not passed through");

   // Every word that leaves the input stage lands in the result stage.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      step.advance |=> rsp_valid_ff)
      else $error("advanced word lost before the result stage");
`endif

endmodule

// ===== tb/fan_pid_heater_pwm_controller_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID and heater PWM controller monitor
// Watches the request, response and register ports, keeps its own copy of the
// controller state, works out the fan duty and heater level of every accepted
// tick and compares each response word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module fan_pid_heater_pwm_controller_monitor
   import fpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fpc_req_if                    req,
   fpc_rsp_if                    rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           words_pending
);

   // One predicted response word.
   typedef struct packed {
      logic [FAN_W-1:0] fan_duty;
      logic             heater_on;
   } tick_drive_type;

   localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

   // Register copies.
   logic [GAIN_W-1:0]   kp;
   logic [GAIN_W-1:0]   ki;
   logic [GAIN_W-1:0]   kd;
   logic [TARGET_W-1:0] setpoint;
   logic                auto_on;

   // Controller state copies.
   logic signed [SUM_W-1:0] err_total;
   logic signed [ERR_W-1:0] last_err;
   logic [CNT_W-1:0]        pwm_count;
   logic                    heat_level;

   tick_drive_type pending_drives[$];

   // Advance the controller state by one tick and return the drive it shows.
   function automatic tick_drive_type control_tick(input logic [TEMP_W-1:0]  temp,
                                                   input logic [FAN_W-1:0]   fan_man,
                                                   input logic [HDUTY_W-1:0] hduty);
      longint         err;
      longint         drive;
      longint         total;
      longint         fan_lo;
      longint         fan_hi;
      tick_drive_type res;
      fan_lo = longint'(FAN_MIN);
      fan_hi = longint'(FAN_MAX);
      if (auto_on) begin
         err   = longint'(temp >> 1) - longint'(setpoint);
         drive = longint'(kp) * err + longint'(ki) * longint'(err_total)
               + longint'(kd) * (err - longint'(last_err));
         if (drive > fan_hi) drive = fan_hi;
         if (drive < fan_lo) drive = fan_lo;
         res.fan_duty = drive[FAN_W-1:0];
         // The error sum saturates at the rails of its signed width.
         total = longint'(err_total) + err;
         if (total > SUM_HI) total = SUM_HI;
         if (total < SUM_LO) total = SUM_LO;
         err_total  = total[SUM_W-1:0];
         last_err   = err[ERR_W-1:0];
         heat_level = 1'b1;
      end else begin
         res.fan_duty = fan_man;
         // Software PWM: off once the count reaches the duty, on again at the wrap.
         pwm_count = pwm_count + CNT_W'(1);
         if (pwm_count >= hduty) heat_level = 1'b0;
         if (pwm_count == HEAT_PERIOD) begin
            if (hduty != '0) heat_level = 1'b1;
            pwm_count = '0;
         end
      end
      res.heater_on = heat_level;
      return res;
   endfunction

   // Track registers, predict on each accepted request and check each response.
   always @(posedge clock) begin
      tick_drive_type want;
      if (reset) begin
         kp             = PROP_GAIN_RST;
         ki             = INTEG_GAIN_RST;
         kd             = DERIV_GAIN_RST;
         setpoint       = TARGET_RST;
         auto_on        = 1'b0;
         err_total      = '0;
         last_err       = '0;
         pwm_count      = '0;
         heat_level     = 1'b0;
         mismatch_count = 0;
         pending_drives.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PROP_GAIN:   kp       = csr_wdata[GAIN_W-1:0];
               CSR_INTEG_GAIN:  ki       = csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN:  kd       = csr_wdata[GAIN_W-1:0];
               CSR_TARGET_TEMP: setpoint = csr_wdata[TARGET_W-1:0];
               CSR_AUTO_MODE:   auto_on  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_drives.size() == 0) begin
               $error("response word with no prediction pending: fan_duty %0d heater_on %0d",
                      rsp.fan_duty, rsp.heater_on);
               mismatch_count++;
            end else begin
               want = pending_drives.pop_front();
               if (rsp.fan_duty !== want.fan_duty) begin
                  $error("fan_duty mismatch: expected %0d, actual %0d",
                         want.fan_duty, rsp.fan_duty);
                  mismatch_count++;
               end
               if (rsp.heater_on !== want.heater_on) begin
                  $error("heater_on mismatch: expected %0d, actual %0d",
                         want.heater_on, rsp.heater_on);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready)
            pending_drives.push_back(control_tick(req.temp_sample, req.fan_duty_manual,
                                                  req.heater_duty_manual));
      end
      words_pending = pending_drives.size();
   end

endmodule

// ===== tb/fan_pid_heater_pwm_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan PID and heater PWM controller testbench
// Drives control ticks and register settings into the controller with random
// gaps and response stalls. A directed opening covers field extremes, the PWM
// wrap, odd heater duties and mode changes; a back-to-back burst swings the
// error sum far negative and then positive; random phases with fresh settings
// follow. The monitor predicts and checks every response word.
// ----------------------------------------------------------------------------
module fan_pid_heater_pwm_controller_tb;
   import fpc_pkg::*;

   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_TICKS   = 120;
   localparam int unsigned NEG_BURST_TICKS = 100;
   localparam int unsigned POS_BURST_TICKS = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_AUTO_MODE + CSR_IDX_W'(1);

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           mismatch_count;
   int unsigned           words_pending;
   int unsigned           ticks_sent;
   int unsigned           settings_used;
   bit                    send_idle;
   bit                    take_idle;
   logic [TARGET_W-1:0]   cur_target;

   fpc_req_if req_chan ();
   fpc_rsp_if rsp_chan ();

   fan_pid_heater_pwm_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   fan_pid_heater_pwm_controller_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the whole run.
   initial begin
      #20ms;
      $display("fan_pid_heater_pwm_controller test failed");
      $finish;
   end

   // Idle cycles before a word; zero throughout when idling is off.
   function automatic int unsigned draw_gap(input bit idle_on);
      if (!idle_on) return 0;
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return $urandom_range(0, 2);
         default: return $urandom_range(0, 16);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         default: return GAIN_W'($urandom_range(0, 40));
      endcase
   endfunction

   // Present one word and hold it until it is taken.
   task automatic send_tick(input logic [TEMP_W-1:0]  temp,
                            input logic [FAN_W-1:0]   fan,
                            input logic [HDUTY_W-1:0] hduty);
      int unsigned gap;
      gap = draw_gap(send_idle);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.temp_sample        <= temp;
      req_chan.fan_duty_manual    <= fan;
      req_chan.heater_duty_manual <= hduty;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Stop sending and wait for every predicted word to come back.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (words_pending != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_TARGET_TEMP) cur_target = data[TARGET_W-1:0];
   endtask

   // Response side: a random stall before each word is taken.
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_gap(take_idle);
         if (stall != 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Stimulus and verdict.
   initial begin
      int          centre;
      logic [TEMP_W-1:0]  temp;
      logic [HDUTY_W-1:0] hduty;
      reset                       = 1'b1;
      req_chan.valid              = 1'b0;
      req_chan.temp_sample        = '0;
      req_chan.fan_duty_manual    = '0;
      req_chan.heater_duty_manual = '0;
      csr_write_en                = 1'b0;
      csr_index                   = '0;
      csr_wdata                   = '0;
      ticks_sent                  = 0;
      settings_used               = 1;
      send_idle                   = 1'b1;
      take_idle                   = 1'b1;
      cur_target                  = TARGET_RST;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Manual mode at reset settings: extremes, zero duty and duty above ten.
      send_tick('0, '0, 4'd0);
      send_tick('1, '1, 4'd15);
      send_tick(10'd512, 8'd128, 4'd10);
      // A full PWM period with a duty of three, through the wrap.
      for (int k = 0; k < 10; k++)
         send_tick(TEMP_W'($urandom_range(0, 1023)), FAN_W'($urandom_range(0, 255)), 4'd3);

      // Switch to automatic; PWM count and PID state carry over.
      settle();
      write_reg(CSR_AUTO_MODE, 10'h3FF);
      settings_used++;
      send_tick('0, 8'd77, 4'd5);
      send_tick('1, 8'd200, 4'd5);
      send_tick(10'd80, 8'd1, 4'd0);
      send_tick(10'd81, 8'd2, 4'd0);
      send_tick(10'd79, 8'd3, 4'd0);

      // Setpoint zero with full derivative gain; writes to spare indexes are ignored.
      settle();
      write_reg(CSR_TARGET_TEMP, '0);
      write_reg(CSR_DERIV_GAIN, '1);
      for (int k = 0; k < 3; k++)
         write_reg(CSR_IDX_W'(CSR_SPARE + k), CSR_DATA_W'($urandom_range(0, 1023)));
      settings_used++;
      send_tick('1, 8'd0, 4'd0);
      send_tick('0, 8'd0, 4'd0);

      // Integral action only at the highest setpoint; the fan goes to its ceiling.
      settle();
      write_reg(CSR_PROP_GAIN, '0);
      write_reg(CSR_INTEG_GAIN, '1);
      write_reg(CSR_DERIV_GAIN, '0);
      write_reg(CSR_TARGET_TEMP, 10'h3FF);
      settings_used++;
      send_tick('0, 8'd0, 4'd0);

      // Back to manual with odd heater duties.
      settle();
      write_reg(CSR_AUTO_MODE, 10'h3FE);
      settings_used++;
      send_tick(10'd600, 8'd33, 4'd11);
      send_tick(10'd601, 8'd34, 4'd5);

      // Back-to-back burst that pushes the error sum far negative, then positive.
      settle();
      send_idle = 1'b0;
      take_idle = 1'b0;
      write_reg(CSR_PROP_GAIN, pick_gain());
      write_reg(CSR_DERIV_GAIN, pick_gain());
      write_reg(CSR_TARGET_TEMP, 10'd255);
      write_reg(CSR_AUTO_MODE, 10'd1);
      settings_used++;
      for (int k = 0; k < NEG_BURST_TICKS; k++)
         send_tick(TEMP_W'($urandom_range(0, 1)), FAN_W'($urandom_range(0, 255)),
                   HDUTY_W'($urandom_range(0, 15)));
      settle();
      write_reg(CSR_TARGET_TEMP, '0);
      settings_used++;
      for (int k = 0; k < POS_BURST_TICKS; k++)
         send_tick(TEMP_W'($urandom_range(1022, 1023)), FAN_W'($urandom_range(0, 255)),
                   HDUTY_W'($urandom_range(0, 15)));

      // Random phases, each with fresh settings and its own idling pattern.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         send_idle = (phase != 3) && ($urandom_range(0, 4) != 0);
         take_idle = (phase != 3) && ($urandom_range(0, 4) != 0);
         write_reg(CSR_PROP_GAIN, pick_gain());
         write_reg(CSR_INTEG_GAIN, pick_gain());
         write_reg(CSR_DERIV_GAIN, pick_gain());
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_TARGET_TEMP, 10'd255);
            1:       write_reg(CSR_TARGET_TEMP, CSR_DATA_W'($urandom_range(0, 1)));
            default: write_reg(CSR_TARGET_TEMP, CSR_DATA_W'($urandom_range(0, 255)));
         endcase
         write_reg(CSR_AUTO_MODE, {9'($urandom_range(0, 511)), 1'(phase % 2)});
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE, 7)), CSR_DATA_W'($urandom));
         settings_used++;
         for (int k = 0; k < PHASE_TICKS; k++) begin
            // Half the time near the setpoint so the fan duty lands inside its clamp.
            case ($urandom_range(0, 3))
               0: temp = TEMP_W'($urandom_range(0, 1023));
               1: temp = ($urandom_range(0, 1) != 0) ? TEMP_W'($urandom_range(0, 1))
                                                     : TEMP_W'($urandom_range(1022, 1023));
               default: begin
                  centre = int'(cur_target) * 2 + int'($urandom_range(0, 80)) - 40;
                  if (centre < 0) centre = 0;
                  if (centre > 1023) centre = 1023;
                  temp = centre[TEMP_W-1:0];
               end
            endcase
            hduty = ($urandom_range(0, 4) == 0) ? HDUTY_W'($urandom_range(11, 15))
                                                : HDUTY_W'($urandom_range(0, 10));
            send_tick(temp, FAN_W'($urandom_range(0, 255)), hduty);
            // Now and then let the pipeline run dry mid-phase.
            if ($urandom_range(0, 59) == 0) settle();
         end
      end

      settle();
      repeat (4) @(negedge clock);
      $display("Ran %0d control ticks over %0d register settings in manual and automatic mode,",
               ticks_sent, settings_used);
      $display("with heater PWM wraps, fan clamping at both ends and large error sums of both signs.");
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("fan_pid_heater_pwm_controller test passed");
      end else begin
         if (words_pending != 0) $error("%0d predicted words never arrived", words_pending);
         $display("fan_pid_heater_pwm_controller test failed");
      end
      $finish;
   end

endmodule
